/* hw/rtl/rsf_pkg.sv */
// rsf_pkg: shared constants, codes and types of the record sector fixup engine
// used by rsf_ctrl, rsf_datapath, the top level and its checker; no dependencies

package rsf_pkg;

    // record geometry
    localparam int RECORD_WORDS     = 2048;
    localparam int SECTOR_BYTES     = 512;
    localparam int SECTOR_WORDS     = SECTOR_BYTES / 2;
    localparam int ADDR_W           = $clog2(RECORD_WORDS);
    localparam int SECTOR_SHIFT     = $clog2(SECTOR_BYTES);
    localparam int SECTOR_WORD_BITS = $clog2(SECTOR_WORDS);
    localparam int MAX_RECORD_BYTES = 2 * RECORD_WORDS;
    localparam int MAX_SECTORS      = MAX_RECORD_BYTES / SECTOR_BYTES;
    localparam int SECT_IDX_W       = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

    // field widths
    localparam int CFG_W    = 13;
    localparam int WORD_W   = 16;
    localparam int INDEX_W  = 11;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] RECORD_BYTES_RESET = 13'd1024;

    // record magics as stored little-endian words
    localparam logic [WORD_W-1:0] MAGIC_BAAD_LO = 16'h4142;
    localparam logic [WORD_W-1:0] MAGIC_BAAD_HI = 16'h4441;
    localparam logic [WORD_W-1:0] MAGIC_HOLE_LO = 16'h4F48;
    localparam logic [WORD_W-1:0] MAGIC_HOLE_HI = 16'h454C;
    localparam logic [WORD_W-1:0] USN_ALL_ONES  = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE      = 3'd0,
        CMD_READ       = 3'd1,
        CMD_POST_READ  = 3'd2,
        CMD_PRE_WRITE  = 3'd3,
        CMD_POST_WRITE = 3'd4
    } cmd_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_TORN    = 2'd1,
        ST_HDR_BAD = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    // memory address sources
    typedef enum logic [2:0] {
        AS_INDEX,
        AS_W0,
        AS_W1,
        AS_W2,
        AS_W3,
        AS_ARR,
        AS_SAVE,
        AS_END
    } addr_sel_t;

    // memory write data sources
    typedef enum logic [2:0] {
        WD_INPUT,
        WD_BAAD_LO,
        WD_BAAD_HI,
        WD_RDATA,
        WD_USN
    } wdata_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_PW_M0,
        S_PW_M1,
        S_HDR_OFS,
        S_HDR_CNT,
        S_USN,
        S_PW_ARR,
        S_PW_RD,
        S_PW_SAVE,
        S_PW_STAMP,
        S_PR_RD,
        S_PR_CMP,
        S_PR_BAAD,
        S_RS_RD,
        S_RS_WR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       cap_lo;
        logic       cap_ofs;
        logic       cap_cnt;
        logic       cap_usn;
        logic       usn_bump;
        logic       idx_clr;
        logic       idx_inc;
        logic       out_load;
        logic       out_from_rdata;
        status_t    out_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_ok;
        logic magic_refused;
        logic hdr_ok;
        logic last_entry;
        logic end_mismatch;
    } dp_stat_t;

endpackage

/* hw/rtl/record_sector_fixup_engine.sv */
// record_sector_fixup_engine: top level of the record sector fixup engine
// depends on rsf_pkg, rsf_ctrl and rsf_datapath

// Holds one disk record of RECORD_WORDS 16-bit words in a single-ported
// memory and answers every accepted word with exactly one result word.
// A read word answers from the registered memory read. The fixups are
// sequenced over the memory port, one access per cycle; a post-read ends
// early when a torn sector is found. Refused or bad-header fixups end
// after the header reads. One word is in work at a time; the next word
// is taken once the result register is free or draining.
// The store needs no clearing pass after reset: words must be written
// before they are read. record_bytes resets to 1024; the user must see
// that it is written on the cfg channel only while the block is idle,
// which the block itself does not enforce.

module record_sector_fixup_engine
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [rsf_pkg::CMD_W-1:0]         command,
    input  logic [rsf_pkg::INDEX_W-1:0]       word_index,
    input  logic [rsf_pkg::WORD_W-1:0]        write_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [rsf_pkg::WORD_W-1:0]        read_data,
    output logic [rsf_pkg::STATUS_W-1:0]      status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rsf_pkg::CFG_W-1:0]         cfg_data
);

    rsf_pkg::dp_cmd_t  dp_cmd;
    rsf_pkg::dp_stat_t dp_stat;
    logic              cfg_we;

    // configuration is always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    rsf_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (dp_stat),
        .cmd          (dp_cmd)
    );

    rsf_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .word_index   (word_index),
        .write_data   (write_data),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .read_data    (read_data),
        .status       (status)
    );

endmodule

/* hw/rtl/rsf_datapath.sv */
// rsf_datapath: record memory, header and fixup registers, result payload
// depends on rsf_pkg; driven by rsf_ctrl through dp_cmd_t

module rsf_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rsf_pkg::CFG_W-1:0]           cfg_data,
    input  logic [rsf_pkg::INDEX_W-1:0]         word_index,
    input  logic [rsf_pkg::WORD_W-1:0]          write_data,
    input  rsf_pkg::dp_cmd_t                    cmd,
    output rsf_pkg::dp_stat_t                   stat,
    output logic [rsf_pkg::WORD_W-1:0]          read_data,
    output logic [rsf_pkg::STATUS_W-1:0]        status
);

    logic [rsf_pkg::WORD_W-1:0]     mem [rsf_pkg::RECORD_WORDS];
    logic [rsf_pkg::WORD_W-1:0]     rdata_reg;
    logic [rsf_pkg::CFG_W-1:0]      record_bytes_reg;
    logic [rsf_pkg::WORD_W-1:0]     lo_reg;
    logic [rsf_pkg::WORD_W-1:0]     ofs_reg;
    logic [rsf_pkg::WORD_W-1:0]     cnt_reg;
    logic [rsf_pkg::WORD_W-1:0]     usn_reg;
    logic [rsf_pkg::WORD_W-1:0]     usn_next;
    logic [rsf_pkg::WORD_W-1:0]     usn_inc;
    logic [rsf_pkg::SECT_IDX_W-1:0] idx_reg;
    logic [rsf_pkg::SECT_IDX_W-1:0] idx_next;
    logic [rsf_pkg::WORD_W-1:0]     read_data_reg;
    logic [rsf_pkg::STATUS_W-1:0]   status_reg;

    logic [rsf_pkg::ADDR_W-1:0]     arr_addr;
    logic [rsf_pkg::ADDR_W-1:0]     save_addr;
    logic [rsf_pkg::ADDR_W-1:0]     end_addr;
    logic [rsf_pkg::ADDR_W-1:0]     addr;
    logic [rsf_pkg::WORD_W-1:0]     wdata;
    logic [rsf_pkg::WORD_W-1:0]     hdr_n;
    logic [17:0]                    hdr_span;
    logic [rsf_pkg::WORD_W-1:0]     last_n;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_bytes_reg <= rsf_pkg::RECORD_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            record_bytes_reg <= cfg_data;
        end
    end

    // address generation
    assign arr_addr  = ofs_reg[rsf_pkg::ADDR_W:1];
    assign save_addr = arr_addr + rsf_pkg::ADDR_W'(idx_reg) + rsf_pkg::ADDR_W'(1);
    assign end_addr  = rsf_pkg::ADDR_W'({idx_reg, {rsf_pkg::SECTOR_WORD_BITS{1'b1}}});

    always_comb
    begin
        unique case (cmd.addr_sel)
            rsf_pkg::AS_INDEX: addr = rsf_pkg::ADDR_W'(word_index);
            rsf_pkg::AS_W0:    addr = rsf_pkg::ADDR_W'(0);
            rsf_pkg::AS_W1:    addr = rsf_pkg::ADDR_W'(1);
            rsf_pkg::AS_W2:    addr = rsf_pkg::ADDR_W'(2);
            rsf_pkg::AS_W3:    addr = rsf_pkg::ADDR_W'(3);
            rsf_pkg::AS_ARR:   addr = arr_addr;
            rsf_pkg::AS_SAVE:  addr = save_addr;
            rsf_pkg::AS_END:   addr = end_addr;
            default:           addr = end_addr;
        endcase
    end

    // write data selection
    always_comb
    begin
        unique case (cmd.wdata_sel)
            rsf_pkg::WD_INPUT:   wdata = write_data;
            rsf_pkg::WD_BAAD_LO: wdata = rsf_pkg::MAGIC_BAAD_LO;
            rsf_pkg::WD_BAAD_HI: wdata = rsf_pkg::MAGIC_BAAD_HI;
            rsf_pkg::WD_RDATA:   wdata = rdata_reg;
            rsf_pkg::WD_USN:     wdata = usn_reg;
            default:             wdata = usn_reg;
        endcase
    end

    // record memory, one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // sequence number bump, skipping zero and all ones
    assign usn_inc = rdata_reg + rsf_pkg::WORD_W'(1);

    always_comb
    begin
        usn_next = rdata_reg;
        if (cmd.usn_bump)
        begin
            if (usn_inc == '0 || usn_inc == rsf_pkg::USN_ALL_ONES)
            begin
                usn_next = rsf_pkg::WORD_W'(1);
            end
            else
            begin
                usn_next = usn_inc;
            end
        end
    end

    // sector entry counter
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + rsf_pkg::SECT_IDX_W'(1);
        end
    end

    // header and fixup working registers, result payload
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.cap_lo)
        begin
            lo_reg <= rdata_reg;
        end
        if (cmd.cap_ofs)
        begin
            ofs_reg <= rdata_reg;
        end
        if (cmd.cap_cnt)
        begin
            cnt_reg <= rdata_reg;
        end
        if (cmd.cap_usn)
        begin
            usn_reg <= usn_next;
        end
        if (cmd.out_load)
        begin
            read_data_reg <= cmd.out_from_rdata ? rdata_reg : '0;
            status_reg    <= cmd.out_status;
        end
    end

    // header check: offset in ofs_reg, entry count on the read port
    assign hdr_n    = rdata_reg - rsf_pkg::WORD_W'(1);
    assign hdr_span = 18'(ofs_reg) + {1'b0, rdata_reg, 1'b0};

    assign stat.hdr_ok =
        (record_bytes_reg[rsf_pkg::SECTOR_SHIFT-1:0] == '0) &&
        (17'(record_bytes_reg) <= 17'(rsf_pkg::MAX_RECORD_BYTES)) &&
        !ofs_reg[0] &&
        (hdr_n == rsf_pkg::WORD_W'(record_bytes_reg >> rsf_pkg::SECTOR_SHIFT)) &&
        (hdr_span <= 18'(record_bytes_reg));

    // fixup loop status
    assign last_n          = cnt_reg - rsf_pkg::WORD_W'(1);
    assign stat.last_entry = (rsf_pkg::WORD_W'(idx_reg) + rsf_pkg::WORD_W'(1)) == last_n;
    assign stat.end_mismatch = rdata_reg != usn_reg;

    assign stat.magic_refused =
        (lo_reg == rsf_pkg::MAGIC_BAAD_LO && rdata_reg == rsf_pkg::MAGIC_BAAD_HI) ||
        (lo_reg == rsf_pkg::MAGIC_HOLE_LO && rdata_reg == rsf_pkg::MAGIC_HOLE_HI);

    assign stat.idx_ok = 32'(word_index) < 32'(rsf_pkg::RECORD_WORDS);

    assign read_data = read_data_reg;
    assign status    = status_reg;

endmodule

/* hw/rtl/rsf_ctrl.sv */
// rsf_ctrl: sequencer for word access and the three fixup commands
// depends on rsf_pkg; commands rsf_datapath through dp_cmd_t

module rsf_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [rsf_pkg::CMD_W-1:0]     command,
    output logic                          result_valid,
    input  logic                          result_stall,
    input  rsf_pkg::dp_stat_t             stat,
    output rsf_pkg::dp_cmd_t              cmd
);

    rsf_pkg::state_t    state_reg;
    rsf_pkg::state_t    state_next;
    rsf_pkg::cmd_code_t op_reg;
    rsf_pkg::cmd_code_t op_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_busy;
    logic               accept;

    // a held result blocks new words until it drains
    assign out_busy   = out_valid_reg && result_stall;
    assign item_stall = (state_reg != rsf_pkg::S_IDLE) || out_busy;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsf_pkg::S_IDLE;
            op_reg        <= rsf_pkg::CMD_WRITE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign op_next = accept ? rsf_pkg::cmd_code_t'(command) : op_reg;

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        rsf_pkg::CMD_READ:
                            state_next = stat.idx_ok ? rsf_pkg::S_RD_WAIT : rsf_pkg::S_IDLE;
                        rsf_pkg::CMD_POST_READ,
                        rsf_pkg::CMD_POST_WRITE:
                            state_next = rsf_pkg::S_HDR_OFS;
                        rsf_pkg::CMD_PRE_WRITE:
                            state_next = rsf_pkg::S_PW_M0;
                        default:
                            state_next = rsf_pkg::S_IDLE;
                    endcase
                end
            end
            rsf_pkg::S_RD_WAIT:  state_next = rsf_pkg::S_IDLE;
            rsf_pkg::S_PW_M0:    state_next = rsf_pkg::S_PW_M1;
            rsf_pkg::S_PW_M1:
                state_next = stat.magic_refused ? rsf_pkg::S_IDLE : rsf_pkg::S_HDR_OFS;
            rsf_pkg::S_HDR_OFS:  state_next = rsf_pkg::S_HDR_CNT;
            rsf_pkg::S_HDR_CNT:
            begin
                if (!stat.hdr_ok)
                begin
                    state_next = rsf_pkg::S_IDLE;
                end
                else if (op_reg == rsf_pkg::CMD_POST_WRITE)
                begin
                    state_next = rsf_pkg::S_RS_RD;
                end
                else
                begin
                    state_next = rsf_pkg::S_USN;
                end
            end
            rsf_pkg::S_USN:
                state_next = (op_reg == rsf_pkg::CMD_PRE_WRITE) ? rsf_pkg::S_PW_ARR
                                                                : rsf_pkg::S_PR_RD;
            rsf_pkg::S_PW_ARR:   state_next = rsf_pkg::S_PW_RD;
            rsf_pkg::S_PW_RD:    state_next = rsf_pkg::S_PW_SAVE;
            rsf_pkg::S_PW_SAVE:  state_next = rsf_pkg::S_PW_STAMP;
            rsf_pkg::S_PW_STAMP:
                state_next = stat.last_entry ? rsf_pkg::S_IDLE : rsf_pkg::S_PW_RD;
            rsf_pkg::S_PR_RD:    state_next = rsf_pkg::S_PR_CMP;
            rsf_pkg::S_PR_CMP:
            begin
                if (stat.end_mismatch)
                begin
                    state_next = rsf_pkg::S_PR_BAAD;
                end
                else if (stat.last_entry)
                begin
                    state_next = rsf_pkg::S_RS_RD;
                end
                else
                begin
                    state_next = rsf_pkg::S_PR_RD;
                end
            end
            rsf_pkg::S_PR_BAAD:  state_next = rsf_pkg::S_IDLE;
            rsf_pkg::S_RS_RD:    state_next = rsf_pkg::S_RS_WR;
            rsf_pkg::S_RS_WR:
                state_next = stat.last_entry ? rsf_pkg::S_IDLE : rsf_pkg::S_RS_RD;
            default:             state_next = rsf_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd                = '0;
        cmd.addr_sel       = rsf_pkg::AS_INDEX;
        cmd.wdata_sel      = rsf_pkg::WD_INPUT;
        cmd.out_status     = rsf_pkg::ST_DONE;
        unique case (state_reg)
            rsf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        rsf_pkg::CMD_WRITE:
                        begin
                            cmd.wr_en    = stat.idx_ok;
                            cmd.out_load = 1'b1;
                        end
                        rsf_pkg::CMD_READ:
                        begin
                            cmd.rd_en    = stat.idx_ok;
                            cmd.out_load = !stat.idx_ok;
                        end
                        rsf_pkg::CMD_POST_READ,
                        rsf_pkg::CMD_POST_WRITE:
                        begin
                            cmd.rd_en    = 1'b1;
                            cmd.addr_sel = rsf_pkg::AS_W2;
                        end
                        rsf_pkg::CMD_PRE_WRITE:
                        begin
                            cmd.rd_en    = 1'b1;
                            cmd.addr_sel = rsf_pkg::AS_W0;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            rsf_pkg::S_RD_WAIT:
            begin
                cmd.out_load       = 1'b1;
                cmd.out_from_rdata = 1'b1;
            end
            // magic check before a pre-write
            rsf_pkg::S_PW_M0:
            begin
                cmd.cap_lo   = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = rsf_pkg::AS_W1;
            end
            rsf_pkg::S_PW_M1:
            begin
                if (stat.magic_refused)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = rsf_pkg::ST_REFUSED;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = rsf_pkg::AS_W2;
                end
            end
            // header fetch and check
            rsf_pkg::S_HDR_OFS:
            begin
                cmd.cap_ofs  = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = rsf_pkg::AS_W3;
            end
            rsf_pkg::S_HDR_CNT:
            begin
                cmd.cap_cnt = 1'b1;
                cmd.idx_clr = 1'b1;
                if (!stat.hdr_ok)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = rsf_pkg::ST_HDR_BAD;
                end
                else if (op_reg != rsf_pkg::CMD_POST_WRITE)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = rsf_pkg::AS_ARR;
                end
            end
            rsf_pkg::S_USN:
            begin
                cmd.cap_usn  = 1'b1;
                cmd.usn_bump = (op_reg == rsf_pkg::CMD_PRE_WRITE);
            end
            // pre-write: stamp the new sequence number, save and stamp each sector end
            rsf_pkg::S_PW_ARR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = rsf_pkg::AS_ARR;
                cmd.wdata_sel = rsf_pkg::WD_USN;
            end
            rsf_pkg::S_PW_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = rsf_pkg::AS_END;
            end
            rsf_pkg::S_PW_SAVE:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = rsf_pkg::AS_SAVE;
                cmd.wdata_sel = rsf_pkg::WD_RDATA;
            end
            rsf_pkg::S_PW_STAMP:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = rsf_pkg::AS_END;
                cmd.wdata_sel = rsf_pkg::WD_USN;
                cmd.idx_inc   = !stat.last_entry;
                cmd.out_load  = stat.last_entry;
            end
            // post-read: compare each sector end with the sequence number, up to the first mismatch
            rsf_pkg::S_PR_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = rsf_pkg::AS_END;
            end
            rsf_pkg::S_PR_CMP:
            begin
                if (stat.end_mismatch)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.addr_sel  = rsf_pkg::AS_W0;
                    cmd.wdata_sel = rsf_pkg::WD_BAAD_LO;
                end
                else if (stat.last_entry)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            rsf_pkg::S_PR_BAAD:
            begin
                cmd.wr_en      = 1'b1;
                cmd.addr_sel   = rsf_pkg::AS_W1;
                cmd.wdata_sel  = rsf_pkg::WD_BAAD_HI;
                cmd.out_load   = 1'b1;
                cmd.out_status = rsf_pkg::ST_TORN;
            end
            // restore saved words into the sector ends
            rsf_pkg::S_RS_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = rsf_pkg::AS_SAVE;
            end
            rsf_pkg::S_RS_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = rsf_pkg::AS_END;
                cmd.wdata_sel = rsf_pkg::WD_RDATA;
                cmd.idx_inc   = !stat.last_entry;
                cmd.out_load  = stat.last_entry;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

/* hw/rtl/rsf_checker.sv */
// rsf_checker: port-level assertions for record_sector_fixup_engine
// depends on rsf_pkg; attached to the top level by the bind below

module rsf_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_stall,
    input logic [rsf_pkg::CMD_W-1:0]         command,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic [rsf_pkg::WORD_W-1:0]        read_data,
    input logic [rsf_pkg::STATUS_W-1:0]      status
);

    // a stalled result word stays offered
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    // a held result blocks the input side
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("input word taken while result is held");

    // a write word answers in the next cycle with done and zero data
    a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && command == rsf_pkg::CMD_WRITE |=>
            result_valid && status == rsf_pkg::ST_DONE && read_data == '0)
        else $error("write word result wrong");

    // only a done result may carry data; every other status has zero data
    a_data_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != rsf_pkg::ST_DONE |-> read_data == '0)
        else $error("fixup result carries data");

endmodule

bind record_sector_fixup_engine rsf_checker u_checker (.*);

/* tb/record_sector_fixup_engine_test.sv */
// record_sector_fixup_engine_test: self-checking bench for the record sector fixup engine
// drives words and record size writes, predicts every result word on its own record image
// depends on rsf_pkg and record_sector_fixup_engine

module record_sector_fixup_engine_test;

    import rsf_pkg::*;

    // header word positions and bench constants
    localparam int HDR_MAGIC_LO  = 0;
    localparam int HDR_MAGIC_HI  = 1;
    localparam int HDR_USA_OFS   = 2;
    localparam int HDR_USA_COUNT = 3;

    localparam logic [WORD_W-1:0] MAGIC_FILE_LO = 16'h4946;
    localparam logic [WORD_W-1:0] MAGIC_FILE_HI = 16'h454C;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_WORDS  = 1900;
    localparam int MAX_MSG_LINES = 40;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] rd;
        status_t           st;
    } result_word_t;

    // clock, reset and block ports
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                item_valid;
    logic                item_stall;
    logic [CMD_W-1:0]    command;
    logic [INDEX_W-1:0]  word_index;
    logic [WORD_W-1:0]   write_data;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [WORD_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;

    // record image kept by the bench, with a map of the words loaded so far
    logic [WORD_W-1:0] image [RECORD_WORDS];
    bit                loaded [RECORD_WORDS];
    int                loaded_list [$];
    logic [CFG_W-1:0]  size_bytes;

    result_word_t pending_results [$];

    int  items_sent       = 0;
    int  results_checked  = 0;
    int  mismatch_count   = 0;
    int  loads_sent       = 0;
    int  reads_sent       = 0;
    int  fixups_sent      = 0;
    int  size_settings    = 0;
    int  fixup_status_count [4];
    int  cycle_count      = 0;
    int  stall_left       = 0;
    bit  no_gap_in        = 1'b0;
    bit  no_stall_out     = 1'b0;

    record_sector_fixup_engine u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .word_index   (word_index),
        .write_data   (write_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_data    (read_data),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // header check: size a sector multiple within the store, even offset,
    // count matching the sector count, whole array inside the record
    function automatic bit usa_header_ok(output int arr, output int nfix);
        logic [WORD_W-1:0] cnt_less_one;
        int                ofs;
        int                sz;
        ofs          = image[HDR_USA_OFS];
        cnt_less_one = image[HDR_USA_COUNT] - 16'd1;
        nfix         = cnt_less_one;
        sz           = size_bytes;
        arr          = ofs / 2;
        return (sz % SECTOR_BYTES == 0) && (sz <= MAX_RECORD_BYTES) && (ofs % 2 == 0)
            && (sz / SECTOR_BYTES == nfix) && (ofs + 2 * (nfix + 1) <= sz);
    endfunction

    // saved array entries go back to the sector ends, in sector order
    function automatic void restore_saved_words(input int arr, input int nfix);
        for (int i = 0; i < nfix; i++)
            image[(i + 1) * SECTOR_WORDS - 1] = image[arr + 1 + i];
    endfunction

    // expected result of one word, applied to the record image
    function automatic void apply_to_image(input logic [CMD_W-1:0] cmd, input int idx,
                                           input logic [WORD_W-1:0] data,
                                           output logic [WORD_W-1:0] rd, output status_t st);
        int                arr;
        int                nfix;
        int                tail;
        logic [WORD_W-1:0] usn;
        bit                torn;
        rd = '0;
        st = ST_DONE;
        case (cmd)
            CMD_WRITE:
                if (idx < RECORD_WORDS)
                begin
                    image[idx] = data;
                    if (!loaded[idx])
                    begin
                        loaded[idx] = 1'b1;
                        loaded_list.push_back(idx);
                    end
                end
            CMD_READ:
                if (idx < RECORD_WORDS)
                    rd = image[idx];
            CMD_POST_READ:
                if (!usa_header_ok(arr, nfix))
                    st = ST_HDR_BAD;
                else
                begin
                    usn  = image[arr];
                    torn = 1'b0;
                    for (int i = 0; i < nfix; i++)
                        if (image[(i + 1) * SECTOR_WORDS - 1] != usn)
                            torn = 1'b1;
                    if (torn)
                    begin
                        image[HDR_MAGIC_LO] = MAGIC_BAAD_LO;
                        image[HDR_MAGIC_HI] = MAGIC_BAAD_HI;
                        st = ST_TORN;
                    end
                    else
                        restore_saved_words(arr, nfix);
                end
            CMD_PRE_WRITE:
                if ((image[HDR_MAGIC_LO] == MAGIC_BAAD_LO && image[HDR_MAGIC_HI] == MAGIC_BAAD_HI)
                    || (image[HDR_MAGIC_LO] == MAGIC_HOLE_LO
                        && image[HDR_MAGIC_HI] == MAGIC_HOLE_HI))
                    st = ST_REFUSED;
                else if (!usa_header_ok(arr, nfix))
                    st = ST_HDR_BAD;
                else
                begin
                    usn = image[arr] + 16'd1;
                    if (usn == USN_ALL_ONES || usn == '0)
                        usn = 16'd1;
                    image[arr] = usn;
                    for (int i = 0; i < nfix; i++)
                    begin
                        tail                 = (i + 1) * SECTOR_WORDS - 1;
                        image[arr + 1 + i]   = image[tail];
                        image[tail]          = usn;
                    end
                end
            CMD_POST_WRITE:
                if (!usa_header_ok(arr, nfix))
                    st = ST_HDR_BAD;
                else
                    restore_saved_words(arr, nfix);
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_MSG_LINES)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_checked, what, got, want);
    endtask

    // result side: compare each accepted word, then draw the next stall
    always @(posedge clk)
    begin
        int           hold;
        result_word_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending, read_data", read_data, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (read_data !== want.rd)
                        report_mismatch($sformatf("command %0d read_data", want.cmd),
                                        read_data, want.rd);
                    if (status !== want.st)
                        report_mismatch($sformatf("command %0d status", want.cmd),
                                        status, want.st);
                end
                results_checked++;
                if ($urandom_range(0, 99) < 2)
                    no_stall_out = !no_stall_out;
                hold = no_stall_out ? 0 : $urandom_range(0, 6);
                stall_left   <= hold;
                result_stall <= (hold != 0);
            end
            else if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                result_stall <= (stall_left > 1);
            end
        end
    end

    // send one word after a random gap and log its expected result
    task automatic send_word(input logic [CMD_W-1:0] cmd, input int idx,
                             input logic [WORD_W-1:0] data);
        int           gap;
        result_word_t want;
        if ($urandom_range(0, 99) < 2)
            no_gap_in = !no_gap_in;
        gap = no_gap_in ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        word_index <= idx[INDEX_W-1:0];
        write_data <= data;
        do @(posedge clk); while (item_stall);
        want.cmd = cmd;
        apply_to_image(cmd, idx, data, want.rd, want.st);
        pending_results.push_back(want);
        items_sent++;
        case (cmd)
            CMD_WRITE: loads_sent++;
            CMD_READ:  reads_sent++;
            CMD_POST_READ, CMD_PRE_WRITE, CMD_POST_WRITE:
            begin
                fixups_sent++;
                fixup_status_count[want.st]++;
            end
            default: ;
        endcase
    endtask

    // stop sending and let every pending result and the engine settle
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_record_size(input logic [CFG_W-1:0] rec_size);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= rec_size;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_bytes = rec_size;
        size_settings++;
    endtask

    // a fixup may only touch loaded words: load whatever it would read first
    task automatic run_fixup(input logic [CMD_W-1:0] cmd);
        int arr;
        int nfix;
        for (int w = HDR_MAGIC_LO; w <= HDR_USA_COUNT; w++)
            if (!loaded[w])
                send_word(CMD_WRITE, w, 16'($urandom));
        if (usa_header_ok(arr, nfix))
        begin
            for (int i = 0; i <= nfix; i++)
                if (!loaded[arr + i])
                    send_word(CMD_WRITE, arr + i, 16'($urandom));
            for (int k = 1; k <= nfix; k++)
                if (!loaded[k * SECTOR_WORDS - 1])
                    send_word(CMD_WRITE, k * SECTOR_WORDS - 1, 16'($urandom));
        end
        send_word(cmd, $urandom_range(0, RECORD_WORDS - 1), 16'($urandom));
    endtask

    // header, array and sector ends of a record as read from disk;
    // array entries that fall on header words keep the header values
    task automatic load_record(input int nsec, input logic [WORD_W-1:0] ofs,
                               input logic [WORD_W-1:0] cnt, input logic [WORD_W-1:0] usn,
                               input logic [WORD_W-1:0] mlo, input logic [WORD_W-1:0] mhi);
        int arr;
        arr = ofs / 2;
        send_word(CMD_WRITE, HDR_MAGIC_LO, mlo);
        send_word(CMD_WRITE, HDR_MAGIC_HI, mhi);
        send_word(CMD_WRITE, HDR_USA_OFS, ofs);
        send_word(CMD_WRITE, HDR_USA_COUNT, cnt);
        for (int i = 0; i <= nsec; i++)
            if (arr + i > HDR_USA_COUNT && arr + i < RECORD_WORDS)
                send_word(CMD_WRITE, arr + i, (i == 0) ? usn : 16'($urandom));
        for (int k = 1; k <= nsec; k++)
            send_word(CMD_WRITE, k * SECTOR_WORDS - 1,
                      ($urandom_range(0, 9) < 8) ? usn : 16'($urandom));
    endtask

    // word load and read at the top of the store, unused commands
    task automatic test_word_access();
        send_word(CMD_WRITE, RECORD_WORDS - 1, 16'hFFFF);
        send_word(CMD_READ, RECORD_WORDS - 1, 16'h0000);
        send_word(CMD_SPARE_HI, RECORD_WORDS - 1, 16'hFFFF);
        send_word(CMD_SPARE_LO, 0, 16'h0000);
    endtask

    // walk one two-sector record through every fixup outcome
    task automatic test_fixup_cases();
        int arr_word;
        arr_word = 'h30 / 2;
        load_record(2, 16'h0030, 16'd3, 16'hFFFE, MAGIC_FILE_LO, MAGIC_FILE_HI);
        // FFFE steps to the all-ones value, which becomes 1
        run_fixup(CMD_PRE_WRITE);
        // sector ends carry the sequence number: clean, saved words go back
        run_fixup(CMD_POST_READ);
        // all-ones steps to zero, which becomes 1
        send_word(CMD_WRITE, arr_word, USN_ALL_ONES);
        run_fixup(CMD_PRE_WRITE);
        run_fixup(CMD_POST_WRITE);
        // restored ends no longer match: torn transfer, BAAD stamped
        run_fixup(CMD_POST_READ);
        run_fixup(CMD_PRE_WRITE);
        // post-write does not check the magic
        run_fixup(CMD_POST_WRITE);
        send_word(CMD_WRITE, HDR_MAGIC_LO, MAGIC_HOLE_LO);
        send_word(CMD_WRITE, HDR_MAGIC_HI, MAGIC_HOLE_HI);
        run_fixup(CMD_PRE_WRITE);
        // odd array offset
        send_word(CMD_WRITE, HDR_USA_OFS, 16'h0031);
        run_fixup(CMD_POST_READ);
        // last entry on the last record word, over the second sector end
        send_word(CMD_WRITE, HDR_USA_OFS, 16'd1018);
        run_fixup(CMD_POST_WRITE);
        // one entry past the record end
        send_word(CMD_WRITE, HDR_USA_OFS, 16'd1020);
        run_fixup(CMD_POST_WRITE);
    endtask

    // one record: random layout, then a random mix of word traffic and fixups
    task automatic run_record_session(input int nsec);
        logic [WORD_W-1:0] ofs;
        logic [WORD_W-1:0] cnt;
        logic [WORD_W-1:0] usn;
        logic [WORD_W-1:0] mlo;
        logic [WORD_W-1:0] mhi;
        logic [WORD_W-1:0] data;
        int                pick;
        int                max_ofs;
        int                arr;
        int                nfix;
        int                tail;
        max_ofs = nsec * SECTOR_BYTES - 2 * (nsec + 1);

        // magic
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            mlo = MAGIC_FILE_LO;
            mhi = MAGIC_FILE_HI;
        end
        else if (pick < 88)
        begin
            mlo = MAGIC_BAAD_LO;
            mhi = MAGIC_BAAD_HI;
        end
        else if (pick < 95)
        begin
            mlo = MAGIC_HOLE_LO;
            mhi = MAGIC_HOLE_HI;
        end
        else
        begin
            mlo = 16'($urandom);
            mhi = 16'($urandom);
        end

        // array placement, including overlap with the header and with sector ends
        pick = $urandom_range(0, 99);
        if (pick < 55)
            ofs = 16'(2 * $urandom_range(4, 48));
        else if (pick < 65)
            ofs = 16'(2 * $urandom_range(0, HDR_USA_COUNT));
        else if (pick < 77)
            ofs = 16'(max_ofs);
        else if (pick < 82)
            ofs = 16'(max_ofs + 2);
        else if (pick < 87)
            ofs = 16'(2 * $urandom_range(4, 48) + 1);
        else
            ofs = 16'(2 * (SECTOR_WORDS - 1 - $urandom_range(0, nsec)));

        cnt = ($urandom_range(0, 99) < 85) ? 16'(nsec + 1) : 16'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 8)
            usn = 16'hFFFE;
        else if (pick < 13)
            usn = USN_ALL_ONES;
        else if (pick < 18)
            usn = 16'h0000;
        else
            usn = 16'($urandom);

        load_record(nsec, ofs, cnt, usn, mlo, mhi);

        repeat ($urandom_range(8, 24))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // word load: body, a sector end, or anywhere in the store
                tail = $urandom_range(0, 9);
                if (tail < 6)
                    send_word(CMD_WRITE, $urandom_range(HDR_USA_COUNT + 1,
                              nsec * SECTOR_WORDS - 1), 16'($urandom));
                else if (tail < 8)
                begin
                    if (usa_header_ok(arr, nfix) && $urandom_range(0, 1))
                        data = image[arr];
                    else
                        data = 16'($urandom);
                    send_word(CMD_WRITE, $urandom_range(1, nsec) * SECTOR_WORDS - 1, data);
                end
                else
                    send_word(CMD_WRITE, $urandom_range(0, RECORD_WORDS - 1), 16'($urandom));
            end
            else if (pick < 45)
            begin
                tail = $urandom_range(1, nsec) * SECTOR_WORDS - 1;
                if (!loaded[tail] || $urandom_range(0, 9) < 7)
                    tail = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                send_word(CMD_READ, tail, 16'($urandom));
            end
            else if (pick < 60)
            begin
                // protect, then read back as from disk
                run_fixup(CMD_PRE_WRITE);
                run_fixup(CMD_POST_READ);
            end
            else if (pick < 70)
                run_fixup(CMD_PRE_WRITE);
            else if (pick < 80)
                run_fixup(CMD_POST_READ);
            else if (pick < 90)
                run_fixup(CMD_POST_WRITE);
            else if (pick < 94)
                send_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                          $urandom_range(0, RECORD_WORDS - 1), 16'($urandom));
            else
                send_word(CMD_WRITE, $urandom_range(HDR_MAGIC_LO, HDR_USA_COUNT),
                          16'($urandom));
        end
    endtask

    // random phases, each with its own record size
    task automatic test_random_sessions();
        logic [CFG_W-1:0] rec_size;
        logic [CFG_W-1:0] size_plan [4];
        int               stop_at;
        int               phase;
        int               pick;
        int               nsec;
        size_plan = '{13'd0, 13'h1FFF, 13'd4096, 13'd512};
        stop_at   = items_sent + RANDOM_WORDS;
        phase     = 0;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (phase < 4)
                rec_size = size_plan[phase];
            else if (pick < 75)
                rec_size = 13'($urandom_range(1, MAX_SECTORS) * SECTOR_BYTES);
            else if (pick < 90)
                rec_size = 13'($urandom_range(0, 8191));
            else
                rec_size = 13'($urandom_range(1, MAX_SECTORS) * SECTOR_BYTES
                               + 2 * $urandom_range(1, 255));
            set_record_size(rec_size);
            if (rec_size != 0 && rec_size % SECTOR_BYTES == 0 && rec_size <= MAX_RECORD_BYTES)
                nsec = rec_size / SECTOR_BYTES;
            else
                nsec = $urandom_range(1, MAX_SECTORS);
            repeat ($urandom_range(2, 4))
                run_record_session(nsec);
            phase++;
        end
    endtask

    initial
    begin
        item_valid = 1'b0;
        command    = CMD_WRITE;
        word_index = '0;
        write_data = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        foreach (image[i])
            image[i] = '0;
        foreach (fixup_status_count[i])
            fixup_status_count[i] = 0;
        size_bytes = RECORD_BYTES_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_word_access();
        test_fixup_cases();
        test_random_sessions();
        wait_idle();

        $display("%0d words sent: %0d loads, %0d reads, %0d fixups over %0d record sizes",
                 items_sent, loads_sent, reads_sent, fixups_sent, size_settings);
        $display("fixup outcomes: done %0d, torn %0d, bad header %0d, refused %0d; %0d checked",
                 fixup_status_count[ST_DONE], fixup_status_count[ST_TORN],
                 fixup_status_count[ST_HDR_BAD], fixup_status_count[ST_REFUSED],
                 results_checked);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
